/* design/clrps_pkg.sv */
`default_nettype none

package clrps_pkg;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_REQUEST_INTERVAL = 3'd0,
      CSR_PROFILE_SWITCH   = 3'd1,
      CSR_PROFILE_RELOCK   = 3'd2,
      CSR_BAUD_DWELL       = 3'd3,
      CSR_BAUD_RESCAN      = 3'd4,
      CSR_AUTOSCAN_ENABLE  = 3'd5,
      CSR_CANDIDATE_COUNT  = 3'd6
   } csr_index_type;

   // Item operation codes
   localparam logic OP_TICK     = 1'b0;
   localparam logic OP_RESPONSE = 1'b1;

   // Register reset values
   localparam logic [15:0] RST_REQUEST_INTERVAL = 16'd100;
   localparam logic [15:0] RST_PROFILE_SWITCH   = 16'd500;
   localparam logic [15:0] RST_PROFILE_RELOCK   = 16'd2000;
   localparam logic [15:0] RST_BAUD_DWELL       = 16'd2000;
   localparam logic [15:0] RST_BAUD_RESCAN      = 16'd10000;
   localparam logic        RST_AUTOSCAN_ENABLE  = 1'b1;
   localparam logic [3:0]  RST_CANDIDATE_COUNT  = 4'd4;

   typedef struct packed {
      logic        op;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic       send_request;
      logic       request_profile;
      logic [2:0] baud_index;
      logic       baud_changed;
      logic       baud_locked;
      logic       profile_locked;
   } rsp_type;

   typedef struct packed {
      logic [15:0] request_interval_ms;
      logic [15:0] profile_switch_ms;
      logic [15:0] profile_relock_ms;
      logic [15:0] baud_dwell_ms;
      logic [15:0] baud_rescan_ms;
      logic        autoscan_enable;
      logic [3:0]  baud_candidate_count;
   } cfg_type;

   // Link search state, less the rate index whose width follows the candidate limit
   typedef struct packed {
      logic [31:0] newest_frame_ms;
      logic        response_seen;
      logic        rate_locked;
      logic [31:0] last_rate_switch_ms;
      logic        current_profile;
      logic        profile_of_last_request;
      logic        profile_lock;
      logic [31:0] last_profile_switch_ms;
      logic [31:0] last_request_ms;
   } state_type;

endpackage

`default_nettype wire

/* design/can_link_rate_and_profile_search.sv */
// Bit-rate and request-profile search for a polled CAN link.
// req_ channel: one item per transfer, op selects a service tick or an
//   accepted-response event, now_ms is the wrapping millisecond time.
// rsp_ channel: exactly one result per item, in item order, carrying the
//   request strobe, the request profile, the bit-rate candidate index and
//   the lock flags as they stand after the item.
// csr_ channel: register writes by index, ready whenever reset is low; write
//   only while no item is in flight. Indexes past the register list are ignored.
// Items pass through an input register and one pass of compare-and-update
//   logic into the result register; one item per cycle is sustained while
//   rsp_stall is low. The state feedback loop closes in that single logic pass.
// When rsp_stall holds a finished result, one more item is still taken into
//   the input register; req_stall rises only when both registers are full.
// Synchronous reset clears all search state (no frame seen, index 0,
//   unlocked) and loads register defaults; req_stall is held high during reset.
`default_nettype none

module can_link_rate_and_profile_search #(
   parameter int MAX_RATE_CANDIDATES = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  clrps_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output clrps_pkg::rsp_type  rsp_data,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import clrps_pkg::*;

   localparam int IDX_W = (MAX_RATE_CANDIDATES > 1) ? $clog2(MAX_RATE_CANDIDATES) : 1;

   cfg_type          cfg_ff;
   state_type        st_ff;
   state_type        st_in;
   logic [IDX_W-1:0] idx_ff;
   logic [IDX_W-1:0] idx_in;
   logic             stage_valid_ff;
   req_type          stage_data_ff;
   logic             rsp_valid_ff;
   rsp_type          rsp_data_ff;
   rsp_type          rsp_data_in;
   logic             advance;
   logic             req_take;

   assign csr_ready = !reset;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.request_interval_ms  <= RST_REQUEST_INTERVAL;
         cfg_ff.profile_switch_ms    <= RST_PROFILE_SWITCH;
         cfg_ff.profile_relock_ms    <= RST_PROFILE_RELOCK;
         cfg_ff.baud_dwell_ms        <= RST_BAUD_DWELL;
         cfg_ff.baud_rescan_ms       <= RST_BAUD_RESCAN;
         cfg_ff.autoscan_enable      <= RST_AUTOSCAN_ENABLE;
         cfg_ff.baud_candidate_count <= RST_CANDIDATE_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_REQUEST_INTERVAL: cfg_ff.request_interval_ms  <= csr_data;
            CSR_PROFILE_SWITCH:   cfg_ff.profile_switch_ms    <= csr_data;
            CSR_PROFILE_RELOCK:   cfg_ff.profile_relock_ms    <= csr_data;
            CSR_BAUD_DWELL:       cfg_ff.baud_dwell_ms        <= csr_data;
            CSR_BAUD_RESCAN:      cfg_ff.baud_rescan_ms       <= csr_data;
            CSR_AUTOSCAN_ENABLE:  cfg_ff.autoscan_enable      <= csr_data[0];
            CSR_CANDIDATE_COUNT:  cfg_ff.baud_candidate_count <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // Handshake: the stage moves on when the result register is free or drains
   assign advance   = stage_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (stage_valid_ff && !advance);
   assign req_take  = req_valid && !req_stall;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= req_take || (stage_valid_ff && !advance);
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         stage_data_ff <= req_data;
      end
   end

   clrps_step #(
      .MAX_RATE_CANDIDATES (MAX_RATE_CANDIDATES)
   ) u_step (
      .cfg      (cfg_ff),
      .st       (st_ff),
      .idx      (idx_ff),
      .item     (stage_data_ff),
      .st_next  (st_in),
      .idx_next (idx_in),
      .result   (rsp_data_in)
   );

   // Search state: update once per item as it leaves the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= '0;
         idx_ff <= '0;
      end else if (advance) begin
         st_ff  <= st_in;
         idx_ff <= idx_in;
      end
   end

   // Result register: hold while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= advance || (rsp_valid_ff && rsp_stall);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* design/clrps_step.sv */
`default_nettype none

module clrps_step #(
   parameter int MAX_RATE_CANDIDATES = 8
) (
   input  clrps_pkg::cfg_type   cfg,
   input  clrps_pkg::state_type st,
   input  logic [((MAX_RATE_CANDIDATES > 1) ? $clog2(MAX_RATE_CANDIDATES) : 1)-1:0] idx,
   input  clrps_pkg::req_type   item,
   output clrps_pkg::state_type st_next,
   output logic [((MAX_RATE_CANDIDATES > 1) ? $clog2(MAX_RATE_CANDIDATES) : 1)-1:0] idx_next,
   output clrps_pkg::rsp_type   result
);
   import clrps_pkg::*;

   localparam int IDX_W = (MAX_RATE_CANDIDATES > 1) ? $clog2(MAX_RATE_CANDIDATES) : 1;
   localparam int CNT_W = $clog2(MAX_RATE_CANDIDATES + 1) + 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_RATE_CANDIDATES);

   logic [31:0]      now;
   logic [31:0]      since_frame;
   logic [31:0]      since_rate_switch;
   logic [31:0]      since_request;
   logic [31:0]      since_profile_switch;
   logic             frame_known;
   logic [CNT_W-1:0] count_eff;
   logic [CNT_W-1:0] idx_inc;
   logic             changed;
   logic             send;
   state_type        s;
   logic [IDX_W-1:0] i;
   logic [IDX_W+2:0] idx_wide;

   assign now               = item.now_ms;
   assign since_frame       = now - st.newest_frame_ms;
   assign since_rate_switch = now - st.last_rate_switch_ms;
   assign since_request     = now - st.last_request_ms;
   assign frame_known       = (st.newest_frame_ms != 32'd0);

   // Clamp the candidate count to one through the limit
   always_comb begin
      count_eff = CNT_W'(cfg.baud_candidate_count);
      if (cfg.baud_candidate_count == 4'd0) begin
         count_eff = CNT_W'(1);
      end
      if (count_eff > MAX_CNT) begin
         count_eff = MAX_CNT;
      end
   end

   assign idx_inc = CNT_W'(idx) + CNT_W'(1);

   // A response notes the frame; a tick: sweep, profile, request timer
   always_comb begin
      s                    = st;
      i                    = idx;
      changed              = 1'b0;
      send                 = 1'b0;
      since_profile_switch = now - st.last_profile_switch_ms;
      if (item.op == OP_RESPONSE) begin
         s.newest_frame_ms = now;
         s.response_seen   = 1'b1;
      end else begin
         // Bit-rate sweep
         if (cfg.autoscan_enable) begin
            if (st.rate_locked) begin
               if (frame_known && (since_frame >= {16'd0, cfg.baud_rescan_ms})) begin
                  s.rate_locked         = 1'b0;
                  s.last_rate_switch_ms = now;
               end
            end else if (st.response_seen) begin
               s.rate_locked = 1'b1;
            end else if (since_rate_switch >= {16'd0, cfg.baud_dwell_ms}) begin
               i = (idx_inc >= count_eff) ? '0 : idx_inc[IDX_W-1:0];
               s.last_rate_switch_ms    = now;
               s.profile_lock           = 1'b0;
               s.current_profile        = 1'b0;
               s.last_profile_switch_ms = now;
               changed                  = 1'b1;
            end
         end
         // Request profile
         if (frame_known && (since_frame < {16'd0, cfg.profile_relock_ms})) begin
            if (!s.profile_lock) begin
               s.current_profile = st.profile_of_last_request;
               s.profile_lock    = 1'b1;
            end
         end else if (s.profile_lock) begin
            s.profile_lock           = 1'b0;
            s.last_profile_switch_ms = now;
         end
         if (s.last_profile_switch_ms == now) begin
            since_profile_switch = 32'd0;
         end
         if (!s.profile_lock && (since_profile_switch >= {16'd0, cfg.profile_switch_ms})) begin
            s.current_profile        = ~s.current_profile;
            s.last_profile_switch_ms = now;
         end
         // Periodic request timer
         if (since_request >= {16'd0, cfg.request_interval_ms}) begin
            send                      = 1'b1;
            s.profile_of_last_request = s.current_profile;
            s.last_request_ms         = now;
         end
      end
   end

   assign st_next  = s;
   assign idx_next = i;
   assign idx_wide = {3'd0, i};

   // Build the result from the updated state
   always_comb begin
      result.send_request    = send;
      result.request_profile = s.current_profile;
      result.baud_index      = idx_wide[2:0];
      result.baud_changed    = changed;
      result.baud_locked     = s.rate_locked | ~cfg.autoscan_enable;
      result.profile_locked  = s.profile_lock;
   end

endmodule

`default_nettype wire

/* design/clrps_check.sv */
`default_nettype none

module clrps_check (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_stall,
   input wire clrps_pkg::rsp_type rsp_data,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall
);
   import clrps_pkg::*;

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or dropped while stalled");

   // No result straight out of reset
   a_rsp_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // Input backs up only when the result register is full and stalled
   a_skid: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with room in the result register");

   // A rate advance is only possible while the sweep is unlocked
   a_change_unlocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.baud_changed |-> !rsp_data.baud_locked)
      else $error("rate advanced while reported locked");

   // A stalled request keeps its valid until it transfers
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid)
      else $error("request valid dropped while stalled");

endmodule

bind can_link_rate_and_profile_search clrps_check u_clrps_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_data  (rsp_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall)
);

`default_nettype wire
